[src/sacft_pkg.sv]
package sacft_pkg;

   // cache geometry
   localparam int MAX_WAYS     = 8;
   localparam int WAY_W        = $clog2(MAX_WAYS);
   localparam int WAYS_W       = $clog2(MAX_WAYS + 1);
   localparam int MAX_SETS     = 256;
   localparam int SET_W        = $clog2(MAX_SETS);
   localparam int MAX_SET_BITS = SET_W;
   localparam int SBITS_W      = $clog2(MAX_SET_BITS + 1);
   localparam int ADDR_W       = 32;
   localparam int OFF_W        = 5;
   localparam int LINE_W       = WAY_W + SET_W;
   localparam int LINES        = MAX_WAYS * MAX_SETS;

   // per-set metadata row: fifo pointer above the valid bits
   localparam int META_W = MAX_WAYS + WAY_W;

   // config port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_OFFSET_BITS    = 2'd0,
      REG_SET_INDEX_BITS = 2'd1,
      REG_WAYS_IN_USE    = 2'd2
   } reg_index_type;

   // effective (clamped) configuration
   typedef struct packed {
      logic [OFF_W-1:0]   offset_bits;
      logic [SBITS_W-1:0] set_bits;
      logic [WAYS_W-1:0]  ways;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_EVICT_READ,
      ST_FINISH
   } state_type;

endpackage

[src/set_assoc_cache_fifo_tags.sv]
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: byte_address
// rsp      out  rsp_tvalid/rsp_tready  tdata: way_used, evicted_block; tuser: was_hit, replaced
// csr      in   psel/penable/pwrite    offset_bits, set_index_bits, ways_in_use
//
// a lookup steps way by way until a hit or the last way in use, with one more tag read on
// an eviction; one tag comparator is stepped over the ways, one tag ram read per way
// after reset a clearing pass over all 256 sets zeroes the valid bits and fifo pointers;
// req_tready stays low until it ends
// a finished result waits in the output register; the next request is taken meanwhile and
// its lookup stalls only at the point where it must write back and present its result
module set_assoc_cache_fifo_tags
   import sacft_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request transfer
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] byte_address
   // response transfer
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // [2:0] way_used, [34:3] evicted_block, zero pad
   output logic [1:0]            rsp_tuser,   // [0] was_hit, [1] replaced
   // config
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   sacft_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer state
   state_type           state_ff, state_in;
   logic [SET_W-1:0]    clear_cnt_ff;
   logic [WAY_W-1:0]    way_cnt_ff;
   logic [SET_W-1:0]    set_ff;
   logic [ADDR_W-1:0]   tag_ff;
   logic                hit_ff;
   logic                repl_ff;
   logic [WAY_W-1:0]    way_sel_ff;

   // output register
   logic                rsp_tvalid_ff;
   logic [WAY_W-1:0]    rsp_way_ff;
   logic [ADDR_W-1:0]   rsp_evicted_ff;
   logic                rsp_hit_ff;
   logic                rsp_repl_ff;

   // metadata ram: valid bits and fifo pointer per set
   logic [META_W-1:0]   meta_mem [MAX_SETS];
   logic [META_W-1:0]   meta_q;
   logic                meta_re, meta_we;
   logic [SET_W-1:0]    meta_raddr, meta_waddr;
   logic [META_W-1:0]   meta_wdata;

   // tag ram, addressed {way, set}
   logic [ADDR_W-1:0]   tag_mem [LINES];
   logic [ADDR_W-1:0]   tag_q;
   logic                tag_re, tag_we;
   logic [LINE_W-1:0]   tag_raddr, tag_waddr;

   // request split
   logic                req_acc;
   logic [ADDR_W-1:0]   req_block;
   logic [SET_W-1:0]    set_mask;
   logic [SET_W-1:0]    req_set;
   logic [ADDR_W-1:0]   req_tag;

   // set decode
   logic [MAX_WAYS-1:0] line_valid;
   logic [WAY_W-1:0]    fifo_ptr;
   logic [MAX_WAYS-1:0] way_mask;
   logic                set_full;
   logic [WAY_W-1:0]    free_way;
   logic                last_way;
   logic                tag_match;
   logic [WAY_W-1:0]    victim;
   logic [WAY_W-1:0]    next_ptr;
   logic                out_free;
   logic                finish;
   logic [ADDR_W-1:0]   evicted;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;
   assign finish     = (state_ff == ST_FINISH) & out_free;

   // block address, set index and tag
   assign req_block = req_tdata >> cfg.offset_bits;
   assign set_mask  = (SET_W'(1) << cfg.set_bits) - SET_W'(1);
   assign req_set   = req_block[SET_W-1:0] & set_mask;
   assign req_tag   = req_block >> cfg.set_bits;

   assign line_valid = meta_q[MAX_WAYS-1:0];
   assign fifo_ptr   = meta_q[META_W-1:MAX_WAYS];

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++)
         way_mask[w] = (WAYS_W'(w) < cfg.ways);
   end

   assign set_full = ((line_valid & way_mask) == way_mask);

   // lowest invalid way in use
   always_comb begin
      free_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--)
         if (way_mask[w] && !line_valid[w])
            free_way = WAY_W'(w);
   end

   // the shared comparator: one way per pass
   assign last_way  = ({1'b0, way_cnt_ff} == cfg.ways - WAYS_W'(1));
   assign tag_match = line_valid[way_cnt_ff] && (tag_q == tag_ff);

   // stale pointer after the way count was lowered falls back to way 0
   assign victim   = ({1'b0, fifo_ptr} >= cfg.ways) ? '0 : fifo_ptr;
   assign next_ptr = ({1'b0, way_sel_ff} + WAYS_W'(1) == cfg.ways)
                     ? '0 : way_sel_ff + WAY_W'(1);

   assign evicted = repl_ff
                    ? ((tag_q << cfg.set_bits) | ADDR_W'(set_ff))
                    : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:
            if (clear_cnt_ff == SET_W'(MAX_SETS - 1))
               state_in = ST_IDLE;
         ST_IDLE:
            if (req_acc)
               state_in = ST_READ;
         ST_READ:
            state_in = ST_COMPARE;
         ST_COMPARE:
            if (tag_match)
               state_in = ST_FINISH;
            else if (last_way)
               state_in = set_full ? ST_EVICT_READ : ST_FINISH;
            else
               state_in = ST_READ;
         ST_EVICT_READ:
            state_in = ST_FINISH;
         ST_FINISH:
            if (out_free)
               state_in = ST_IDLE;
         default:
            state_in = ST_CLEAR;
      endcase
   end

   // memory controls
   always_comb begin
      meta_re    = req_acc;
      meta_raddr = req_set;
      meta_we    = 1'b0;
      meta_waddr = set_ff;
      meta_wdata = '0;
      tag_re     = 1'b0;
      tag_raddr  = {way_cnt_ff, set_ff};
      tag_we     = 1'b0;
      tag_waddr  = {way_sel_ff, set_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clear_cnt_ff;
         end
         ST_READ:
            tag_re = 1'b1;
         ST_EVICT_READ: begin
            tag_re    = 1'b1;
            tag_raddr = {way_sel_ff, set_ff};
         end
         ST_FINISH: begin
            // a hit leaves the set untouched
            if (out_free && !hit_ff) begin
               tag_we     = 1'b1;
               meta_we    = 1'b1;
               meta_wdata = {repl_ff ? next_ptr : fifo_ptr,
                             line_valid | (MAX_WAYS'(1) << way_sel_ff)};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (meta_we)
         meta_mem[meta_waddr] <= meta_wdata;
      if (meta_re)
         meta_q <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (tag_we)
         tag_mem[tag_waddr] <= tag_ff;
      if (tag_re)
         tag_q <= tag_mem[tag_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR)
            clear_cnt_ff <= clear_cnt_ff + SET_W'(1);
      end
   end

   // lookup working registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         set_ff     <= req_set;
         tag_ff     <= req_tag;
         way_cnt_ff <= '0;
         hit_ff     <= 1'b0;
         repl_ff    <= 1'b0;
      end else if (state_ff == ST_COMPARE) begin
         if (tag_match) begin
            hit_ff     <= 1'b1;
            way_sel_ff <= way_cnt_ff;
         end else if (last_way) begin
            if (set_full) begin
               repl_ff    <= 1'b1;
               way_sel_ff <= victim;
            end else begin
               way_sel_ff <= free_way;
            end
         end else begin
            way_cnt_ff <= way_cnt_ff + WAY_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_tvalid_ff <= 1'b0;
      else if (finish)
         rsp_tvalid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_tvalid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_way_ff     <= way_sel_ff;
         rsp_evicted_ff <= evicted;
         rsp_hit_ff     <= hit_ff;
         rsp_repl_ff    <= repl_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, rsp_evicted_ff, rsp_way_ff};
   assign rsp_tuser  = {rsp_repl_ff, rsp_hit_ff};

endmodule

[src/sacft_csr.sv]
module sacft_csr
   import sacft_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [OFF_W-1:0]   offset_bits_ff;
   logic [SBITS_W-1:0] set_index_bits_ff;
   logic [WAYS_W-1:0]  ways_in_use_ff;
   logic               wr_en;
   reg_index_type      reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff    <= '0;
         set_index_bits_ff <= '0;
         ways_in_use_ff    <= WAYS_W'(1);
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_OFFSET_BITS:    offset_bits_ff    <= csr_pwdata[OFF_W-1:0];
            REG_SET_INDEX_BITS: set_index_bits_ff <= csr_pwdata[SBITS_W-1:0];
            REG_WAYS_IN_USE:    ways_in_use_ff    <= csr_pwdata[WAYS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_OFFSET_BITS:    csr_prdata = CSR_DATA_W'(offset_bits_ff);
         REG_SET_INDEX_BITS: csr_prdata = CSR_DATA_W'(set_index_bits_ff);
         REG_WAYS_IN_USE:    csr_prdata = CSR_DATA_W'(ways_in_use_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // clamp to the implemented geometry
   always_comb begin
      cfg.offset_bits = offset_bits_ff;
      if (set_index_bits_ff > SBITS_W'(MAX_SET_BITS))
         cfg.set_bits = SBITS_W'(MAX_SET_BITS);
      else
         cfg.set_bits = set_index_bits_ff;
      if (ways_in_use_ff == '0)
         cfg.ways = WAYS_W'(1);
      else if (ways_in_use_ff > WAYS_W'(MAX_WAYS))
         cfg.ways = WAYS_W'(MAX_WAYS);
      else
         cfg.ways = ways_in_use_ff;
   end

endmodule

[verif/set_assoc_cache_fifo_tags_test.sv]
`timescale 1ns / 1ps

module set_assoc_cache_fifo_tags_test;
   import sacft_pkg::*;

   // slowest lookup: eight ways scanned plus an eviction
   localparam int SETTLE_CYCLES = 2 * MAX_WAYS + 8;
   // receiver hold-off long enough for the request side to back up
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 75;

   // one lookup outcome as the response transfer reports it
   typedef struct packed {
      logic        was_hit;
      logic [2:0]  way_used;
      logic        replaced;
      logic [31:0] evicted_block;
   } access_outcome_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [39:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // addresses waiting to be offered, outcomes waiting to be answered
   logic [31:0]        address_queue [$];
   access_outcome_type outcome_queue [$];

   // shadow copy of the tag store and its geometry registers
   logic [4:0]  geometry_offset   = 5'd0;
   logic [3:0]  geometry_set_bits = 4'd0;
   logic [3:0]  geometry_ways     = 4'd1;
   bit          line_live [MAX_WAYS][MAX_SETS];
   logic [31:0] line_tags [MAX_WAYS][MAX_SETS];
   int unsigned fifo_next [MAX_SETS];

   int unsigned mismatch_count = 0;
   int unsigned send_gap       = 0;
   int unsigned stall_left     = 0;
   int unsigned hold_requests  = 0;
   int unsigned holds_done     = 0;

   set_assoc_cache_fifo_tags u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

   // idle length for either side: mostly none, some short, a few long
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return 0;
      if (pick < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // look the address up in the shadow store and apply the fill or eviction
   function automatic access_outcome_type lookup_and_fill(input logic [31:0] byte_address);
      int unsigned        sbits, nways, set_idx, hit_way, free_way, victim;
      bit                 hit, have_free;
      logic [31:0]        block, tag;
      access_outcome_type outcome;
      // set bits saturate at the store depth, zero ways acts as one
      sbits = (geometry_set_bits > SET_W) ? SET_W : 32'(geometry_set_bits);
      nways = (geometry_ways == 0) ? 1 :
              (geometry_ways > MAX_WAYS) ? MAX_WAYS : 32'(geometry_ways);
      block   = byte_address >> geometry_offset;
      set_idx = block & ((32'd1 << sbits) - 1);
      tag     = block >> sbits;
      hit = 0;
      have_free = 0;
      hit_way = 0;
      free_way = 0;
      outcome = '0;
      for (int w = 0; w < nways; w++) begin
         if (line_live[w][set_idx]) begin
            if (!hit && line_tags[w][set_idx] == tag) begin
               hit = 1;
               hit_way = w;
            end
         end else if (!have_free) begin
            have_free = 1;
            free_way = w;
         end
      end
      if (hit) begin
         outcome.was_hit  = 1'b1;
         outcome.way_used = 3'(hit_way);
      end else if (have_free) begin
         line_live[free_way][set_idx] = 1;
         line_tags[free_way][set_idx] = tag;
         outcome.way_used = 3'(free_way);
      end else begin
         // a pointer left over from a wider setting falls back to way 0
         victim = (fifo_next[set_idx] >= nways) ? 0 : fifo_next[set_idx];
         outcome.replaced      = 1'b1;
         outcome.way_used      = 3'(victim);
         outcome.evicted_block = (line_tags[victim][set_idx] << sbits) | set_idx;
         line_tags[victim][set_idx] = tag;
         fifo_next[set_idx] = (victim + 1) % nways;
      end
      return outcome;
   endfunction

   // request side: offer queued addresses, predict each one at its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcome_queue.push_back(lookup_and_fill(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (address_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= address_queue.pop_front();
               send_gap = idle_length();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side: random back-pressure, long hold-offs on request, field checks
   always @(posedge clock) begin
      access_outcome_type want, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.was_hit       = rsp_tuser[0];
            got.replaced      = rsp_tuser[1];
            got.way_used      = rsp_tdata[2:0];
            got.evicted_block = rsp_tdata[34:3];
            if (outcome_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: response transfer with no lookup pending, got hit=%0b way=%0d",
                        $time, got.was_hit, got.way_used);
            end else begin
               want = outcome_queue.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: expected hit=%0b way=%0d replaced=%0b evicted=%h",
                           $time, want.was_hit, want.way_used, want.replaced,
                           want.evicted_block);
                  $display("%0t: actual   hit=%0b way=%0d replaced=%0b evicted=%h",
                           $time, got.was_hit, got.way_used, got.replaced,
                           got.evicted_block);
               end
            end
            stall_left = idle_length();
         end
         if (holds_done != hold_requests) begin
            holds_done++;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one register write: setup phase, then access phase until pready
   task automatic write_register(input reg_index_type index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_OFFSET_BITS:    geometry_offset   = value[4:0];
         REG_SET_INDEX_BITS: geometry_set_bits = value[3:0];
         REG_WAYS_IN_USE:    geometry_ways     = value[3:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // all three registers, with random junk above the field half the time
   task automatic set_geometry(input int unsigned off, input int unsigned sb,
                               input int unsigned ways);
      logic [31:0] junk;
      junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
      write_register(REG_OFFSET_BITS, (junk << 5) | off);
      write_register(REG_SET_INDEX_BITS, (junk << 4) | sb);
      write_register(REG_WAYS_IN_USE, (junk << 4) | ways);
   endtask

   // sender pause: everything offered, transferred and answered, then settle
   task automatic wait_until_quiet();
      @(negedge clock);
      while (address_queue.size() > 0 || req_tvalid || outcome_queue.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // well-formed traffic: a few sets, a tag pool a little larger than the ways
   function automatic logic [31:0] shape_address(input int unsigned off, input int unsigned sb,
                                                 input int unsigned ways,
                                                 input logic [31:0] tag_base);
      logic [63:0] blk;
      int unsigned set_idx, set_span;
      if ($urandom_range(0, 99) < 15)
         return $urandom();
      set_span = (sb >= 2) ? 4 : (1 << sb);
      set_idx  = $urandom_range(0, set_span - 1);
      if ($urandom_range(0, 19) == 0)
         set_idx = (1 << sb) - 1;
      blk = ((64'(tag_base) + $urandom_range(0, ways + 2)) << sb) | set_idx;
      return 32'((blk << off) | ($urandom() & ((64'd1 << off) - 1)));
   endfunction

   initial begin
      int unsigned phase_off  [6] = '{2, 6, 0, 31, 12, 5};
      int unsigned phase_sb   [6] = '{3, 8, 1, 5, 0, 4};
      int unsigned phase_ways [6] = '{4, 8, 2, 3, 8, 5};
      logic [31:0] tag_base;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // clearing pass holds req_tready low
      @(negedge clock);
      while (!req_tready) @(negedge clock);

      // default geometry: one set, one way, byte blocks
      set_geometry(0, 0, 1);
      address_queue.push_back(32'h0000_0000);   // cold miss fills way 0
      address_queue.push_back(32'h0000_0000);   // hit
      address_queue.push_back(32'hFFFF_FFFF);   // full set, evicts the zero line
      address_queue.push_back(32'hFFFF_FFFF);
      wait_until_quiet();

      // widest offset, set bits past the store depth, zero ways
      set_geometry(31, 15, 0);
      address_queue.push_back(32'h8000_0000);   // set 1
      address_queue.push_back(32'h7FFF_FFFF);   // set 0, old tag seen under new split
      wait_until_quiet();

      // more ways than the store holds: fill all eight, then rotate
      set_geometry(4, 2, 15);
      for (int t = 1; t <= 9; t++)
         address_queue.push_back(t << 6);
      address_queue.push_back(32'd5 << 6);      // hit in way 5
      wait_until_quiet();

      // fewer ways than the pointer: stale pointer falls back to way 0
      set_geometry(4, 2, 2);
      address_queue.push_back(32'd20 << 6);
      address_queue.push_back(32'd21 << 6);
      address_queue.push_back(32'd3 << 6);      // held in way 3, now outside the search
      address_queue.push_back(32'hFFFF_FFFF);   // top set
      wait_until_quiet();

      // random phases over several geometries
      for (int p = 0; p < 6; p++) begin
         set_geometry(phase_off[p], phase_sb[p], phase_ways[p]);
         tag_base = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 15);
         for (int i = 0; i < RANDOM_ITEMS; i++)
            address_queue.push_back(shape_address(phase_off[p], phase_sb[p],
                                                  phase_ways[p], tag_base));
         // receiver blocks while the sender keeps offering
         if (p == 1 || p == 4)
            hold_requests++;
         wait_until_quiet();
      end

      if (mismatch_count == 0 && outcome_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
src/sacft_pkg.sv
src/sacft_csr.sv
src/set_assoc_cache_fifo_tags.sv
verif/set_assoc_cache_fifo_tags_test.sv
